>>> src/crrc_pkg.sv
// Shared types and codes of the command ring reserve/commit unit.
// No dependencies; every other file of the block imports this package.
package crrc_pkg;

  localparam int unsigned FieldBits = 24;
  localparam int unsigned AddrBits  = 4;
  localparam int unsigned DataBits  = 32;

  typedef logic [FieldBits-1:0] field_t;

  // Function code of an input word
  localparam logic FuncReserve = 1'b0;
  localparam logic FuncCommit  = 1'b1;

  // Register indexes (byte address / 4)
  localparam logic [1:0] RegFifoMin  = 2'd0;
  localparam logic [1:0] RegFifoMax  = 2'd1;
  localparam logic [1:0] RegResvCap  = 2'd2;

  // Error flag bit positions
  localparam int unsigned ErrTooLarge  = 0;
  localparam int unsigned ErrMisalign  = 1;
  localparam int unsigned ErrDoubleRsv = 2;
  localparam int unsigned ErrNoRsv     = 3;

  typedef enum logic [1:0] {
    ST_IN_PLACE = 2'd0,
    ST_BOUNCE   = 2'd1,
    ST_FULL     = 2'd2,
    ST_COMMIT   = 2'd3
  } status_e;

  typedef struct packed {
    field_t fifo_min;
    field_t fifo_max;
    logic   reserve_capable;
  } cfg_t;

  typedef struct packed {
    logic   ld_min;
    field_t min_value;
  } cfg_evt_t;

  typedef struct packed {
    status_e    status;
    field_t     place_offset;
    field_t     first_chunk;
    field_t     second_chunk;
    field_t     write_pointer;
    field_t     reserved_word;
    logic       reserved_write;
    logic [3:0] error_flags;
  } result_t;

endpackage

>>> src/crrc_regs.sv
// Configuration register file behind the APB-style port.
// Depends on crrc_pkg for the register indexes and the config struct.
module crrc_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [crrc_pkg::AddrBits-1:0]  paddr,
  input  logic [crrc_pkg::DataBits-1:0]  pwdata,
  output logic [crrc_pkg::DataBits-1:0]  prdata,
  output logic                           pready,
  output crrc_pkg::cfg_t                 cfg_o,
  output crrc_pkg::cfg_evt_t             evt_o
);
  import crrc_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegFifoMin: cfg_d.fifo_min        = pwdata[FieldBits-1:0];
        RegFifoMax: cfg_d.fifo_max        = pwdata[FieldBits-1:0];
        RegResvCap: cfg_d.reserve_capable = pwdata[0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegFifoMin: prdata = DataBits'(cfg_q.fifo_min);
      RegFifoMax: prdata = DataBits'(cfg_q.fifo_max);
      RegResvCap: prdata = DataBits'(cfg_q.reserve_capable);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o           = cfg_q;
  assign evt_o.ld_min    = wr_en && (reg_idx == RegFifoMin);
  assign evt_o.min_value = pwdata[FieldBits-1:0];

endmodule

>>> src/crrc_calc.sv
// Single-pass decision logic for one reserve or commit word.
// Depends on crrc_pkg; purely combinational, state lives in the top level.
module crrc_calc #(
  parameter int unsigned BOUNCE_BYTES = 1048576,
  parameter int unsigned OFFSET_BITS  = 24
) (
  input  crrc_pkg::cfg_t           cfg_i,
  input  logic [OFFSET_BITS-1:0]   next_cmd_i,
  input  crrc_pkg::field_t         pending_i,
  input  logic                     func_i,
  input  crrc_pkg::field_t         byte_count_i,
  input  crrc_pkg::field_t         stop_offset_i,
  output crrc_pkg::result_t        res_o,
  output logic [OFFSET_BITS-1:0]   next_cmd_o,
  output crrc_pkg::field_t         pending_o,
  output logic                     bounce_we_o,
  output logic                     bounce_o
);
  import crrc_pkg::*;

  localparam int unsigned WideBits = ((OFFSET_BITS > FieldBits) ? OFFSET_BITS : FieldBits) + 3;
  localparam logic [WideBits-1:0] BounceW = WideBits'(BOUNCE_BYTES);

  typedef logic [OFFSET_BITS-1:0] off_t;
  typedef logic [WideBits-1:0]    wide_t;

  off_t  mn_o, mx_o, sum_o, nn_o, nn_wrap;
  wide_t mn_w, mx_w, nc_w, by_w, st_w, sum_w, span_w, room_w;
  logic signed [WideBits-1:0] avail;
  logic  in_place, bounce, fits_room;
  field_t first;

  always_comb begin
    // Offsets live in OFFSET_BITS; compares run in a wider unsigned domain
    mn_o   = OFFSET_BITS'(cfg_i.fifo_min);
    mx_o   = OFFSET_BITS'(cfg_i.fifo_max);
    mn_w   = WideBits'(mn_o);
    mx_w   = WideBits'(mx_o);
    nc_w   = WideBits'(next_cmd_i);
    by_w   = WideBits'(byte_count_i);
    st_w   = WideBits'(stop_offset_i);
    sum_w  = nc_w + by_w;
    span_w = (mx_w >= mn_w) ? (mx_w - mn_w) : '0;
    avail  = $signed(mx_w) - $signed(nc_w) + $signed(st_w) - $signed(mn_w);
    room_w = (mx_w > nc_w) ? (mx_w - nc_w) : '0;

    in_place = 1'b0;
    bounce   = 1'b0;
    if (nc_w >= st_w) begin
      if ((sum_w < mx_w) || ((sum_w == mx_w) && (st_w > mn_w))) begin
        in_place = 1'b1;
      end else if (avail > $signed(by_w)) begin
        bounce = 1'b1;
      end
    end else if (sum_w < st_w) begin
      in_place = 1'b1;
    end
    // Small words may go in place even when the consumer is not capable
    if (in_place && !(cfg_i.reserve_capable || (by_w <= WideBits'(4)))) begin
      in_place = 1'b0;
      bounce   = 1'b1;
    end

    // Commit: split across the ring end and wrap the pointer once
    fits_room = by_w <= room_w;
    first     = fits_room ? byte_count_i : FieldBits'(room_w);
    sum_o     = OFFSET_BITS'(sum_w);
    nn_wrap   = sum_o - (mx_o - mn_o);
    nn_o      = (sum_o >= mx_o) ? nn_wrap : sum_o;

    res_o              = '0;
    res_o.place_offset = FieldBits'(next_cmd_i);
    next_cmd_o         = next_cmd_i;
    pending_o          = pending_i;
    bounce_we_o        = 1'b0;
    bounce_o           = 1'b0;

    if (func_i == FuncReserve) begin
      res_o.error_flags[ErrTooLarge]  = (by_w > BounceW) || (by_w > span_w);
      res_o.error_flags[ErrMisalign]  = byte_count_i[1:0] != 2'b00;
      res_o.error_flags[ErrDoubleRsv] = pending_i != '0;
      if (in_place) begin
        res_o.status         = ST_IN_PLACE;
        pending_o            = byte_count_i;
        bounce_we_o          = 1'b1;
        bounce_o             = 1'b0;
        res_o.reserved_word  = cfg_i.reserve_capable ? byte_count_i : '0;
        res_o.reserved_write = cfg_i.reserve_capable;
      end else if (bounce) begin
        res_o.status = ST_BOUNCE;
        pending_o    = byte_count_i;
        bounce_we_o  = 1'b1;
        bounce_o     = 1'b1;
      end else begin
        res_o.status = ST_FULL;
      end
    end else begin
      res_o.error_flags[ErrNoRsv] = pending_i == '0;
      res_o.status         = ST_COMMIT;
      res_o.first_chunk    = first;
      res_o.second_chunk   = byte_count_i - first;
      res_o.reserved_write = cfg_i.reserve_capable;
      pending_o            = '0;
      next_cmd_o           = nn_o;
    end
    res_o.write_pointer = FieldBits'(next_cmd_o);
  end

endmodule

>>> src/command_ring_reserve_commit_unit.sv
// Producer side of a byte-addressed command ring: reserve and commit words.
// Words pass the input register, then the result register when it is empty
// or drained. Throughput: one word per cycle while out_stall_i is low; both
// form a two-deep pipeline, so a word is taken while a result waits.
// Reset (rst_ni low, asynchronous): registers, write pointer, pending size
// and bounce flag clear to zero; both pipeline stages empty.
module command_ring_reserve_commit_unit #(
  parameter int unsigned BOUNCE_BYTES = 1048576,
  parameter int unsigned OFFSET_BITS  = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [crrc_pkg::AddrBits-1:0]  paddr,
  input  logic [crrc_pkg::DataBits-1:0]  pwdata,
  output logic [crrc_pkg::DataBits-1:0]  prdata,
  output logic                           pready,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           func_i,
  input  logic [23:0]                    byte_count_i,
  input  logic [23:0]                    stop_offset_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     status_o,
  output logic [23:0]                    place_offset_o,
  output logic [23:0]                    first_chunk_o,
  output logic [23:0]                    second_chunk_o,
  output logic [23:0]                    write_pointer_o,
  output logic [23:0]                    reserved_word_o,
  output logic                           reserved_write_o,
  output logic [3:0]                     error_flags_o
);
  import crrc_pkg::*;

  cfg_t     cfg;
  cfg_evt_t evt;

  // Input register stage
  logic   s1_vld_q, s1_vld_d;
  logic   s1_func_q;
  field_t s1_bytes_q, s1_stop_q;

  // Ring state
  logic [OFFSET_BITS-1:0] next_cmd_q, next_cmd_d, calc_nc;
  field_t                 pending_q, pending_d, calc_pend;
  logic                   bounce_q, bounce_d, calc_bwe, calc_bval;

  // Result register stage
  logic    out_vld_q, out_vld_d;
  result_t res_q, calc_res;

  logic in_acc, adv, fire;

  crrc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .evt_o   (evt)
  );

  crrc_calc #(
    .BOUNCE_BYTES (BOUNCE_BYTES),
    .OFFSET_BITS  (OFFSET_BITS)
  ) u_calc (
    .cfg_i         (cfg),
    .next_cmd_i    (next_cmd_q),
    .pending_i     (pending_q),
    .func_i        (s1_func_q),
    .byte_count_i  (s1_bytes_q),
    .stop_offset_i (s1_stop_q),
    .res_o         (calc_res),
    .next_cmd_o    (calc_nc),
    .pending_o     (calc_pend),
    .bounce_we_o   (calc_bwe),
    .bounce_o      (calc_bval)
  );

  // Advance the result register when it is empty or being drained
  assign adv        = !out_vld_q || !out_stall_i;
  assign fire       = s1_vld_q && adv;
  assign in_stall_o = s1_vld_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_vld_d  = in_acc || (s1_vld_q && !adv);
    out_vld_d = adv ? s1_vld_q : out_vld_q;
    // Commit state only for the word that moves into the result register
    next_cmd_d = fire ? calc_nc : next_cmd_q;
    pending_d  = fire ? calc_pend : pending_q;
    bounce_d   = (fire && calc_bwe) ? calc_bval : bounce_q;
    // Writing fifo_min reloads the write pointer
    if (evt.ld_min) begin
      next_cmd_d = OFFSET_BITS'(evt.min_value);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      next_cmd_q <= '0;
      pending_q  <= '0;
      bounce_q   <= 1'b0;
    end else begin
      s1_vld_q   <= s1_vld_d;
      out_vld_q  <= out_vld_d;
      next_cmd_q <= next_cmd_d;
      pending_q  <= pending_d;
      bounce_q   <= bounce_d;
    end
  end

  // Payload registers: load on accept / advance, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_func_q  <= func_i;
      s1_bytes_q <= byte_count_i;
      s1_stop_q  <= stop_offset_i;
    end
    if (fire) begin
      res_q <= calc_res;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign status_o         = res_q.status;
  assign place_offset_o   = res_q.place_offset;
  assign first_chunk_o    = res_q.first_chunk;
  assign second_chunk_o   = res_q.second_chunk;
  assign write_pointer_o  = res_q.write_pointer;
  assign reserved_word_o  = res_q.reserved_word;
  assign reserved_write_o = res_q.reserved_write;
  assign error_flags_o    = res_q.error_flags;

  // A full answer leaves the ring state untouched
  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && calc_res.status == ST_FULL && !evt.ld_min)
      |=> ($stable(next_cmd_q) && $stable(pending_q) && $stable(bounce_q)))
    else $error("ring state changed on a full answer");

  // A bounce placement marks the bounce buffer in use
  a_bounce_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && calc_res.status == ST_BOUNCE) |=> bounce_q)
    else $error("bounce flag not set after bounce placement");

  // The two chunks of a commit cover exactly the committed bytes
  a_chunk_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && s1_func_q == FuncCommit)
      |-> (FieldBits'(calc_res.first_chunk + calc_res.second_chunk) == s1_bytes_q))
    else $error("commit chunks do not sum to byte count");

  // The reserved word is only written for in-place reserves and commits
  a_rword_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.reserved_write)
      |-> (res_q.status == ST_IN_PLACE || res_q.status == ST_COMMIT))
    else $error("reserved word written for bounce or full answer");

  // A commit clears the pending reservation
  a_commit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && s1_func_q == FuncCommit) |=> (pending_q == '0))
    else $error("pending size not cleared by commit");

endmodule
